FILE: rtl/core/dltq_pkg.sv
// ----------------------------------------------------------------------------
// Delta-list timer queue package
// Shared types, codes and defaults for the delta-list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int NumTimersDef = 8;
  localparam int TimeWidthDef = 32;
  localparam int MaxResults   = 8;
  localparam int ActW         = 3;
  localparam int IdW          = 3;
  localparam int IvW          = 32;

  typedef enum logic [ActW-1:0] {
    ACT_SET     = 3'd0,
    ACT_START   = 3'd1,
    ACT_STOP    = 3'd2,
    ACT_RESTART = 3'd3,
    ACT_TICK    = 3'd4
  } action_t;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_STOP_CHK,
    ST_STOP_WALK,
    ST_STOP_FIX,
    ST_SET_WR,
    ST_START_CHK,
    ST_START_WALK,
    ST_START_LINK,
    ST_START_FIN,
    ST_TICK,
    ST_EXP,
    ST_EXP_NEXT,
    ST_ACK,
    ST_OUT_WAIT
  } state_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_STOP_HEAD,
    OP_STOP_STEP,
    OP_STOP_FIX,
    OP_SET_WR,
    OP_START_CHK,
    OP_START_STEP,
    OP_START_LINK,
    OP_START_FIN,
    OP_TICK,
    OP_EXPIRE,
    OP_EXP_END
  } op_t;

  typedef struct packed {
    op_t  op;
  } dltq_cmd_t;

  typedef struct packed {
    logic queued;      // timer of the current command is queued
    logic empty;       // list is empty
    logic is_head;     // current timer is the head
    logic walk_hit;    // stop walk found the timer
    logic walk_end;    // walk ran off the end of the list
    logic ins_front;   // start goes in front of the head
    logic ins_stop;    // start walk found its place
    logic tick_fire;   // tick reached the head delay
    logic exp_more;    // another expiry follows
    logic id_bad;      // timer id out of range
  } dltq_sts_t;

endpackage

FILE: rtl/core/dltq_if.sv
// ----------------------------------------------------------------------------
// Delta-list timer queue channels
// Valid/ready interfaces for the command and result channels.
// ----------------------------------------------------------------------------
interface dltq_in_if;
  logic                     valid;
  logic                     ready;
  logic [dltq_pkg::ActW-1:0] action;
  logic [dltq_pkg::IdW-1:0]  timer_id;
  logic [dltq_pkg::IvW-1:0]  interval;
  modport source (output valid, action, timer_id, interval, input ready);
  modport sink   (input valid, action, timer_id, interval, output ready);
endinterface

interface dltq_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] timer_number;
  logic       status;
  logic       last;
  modport source (output valid, kind, timer_number, status, last, input ready);
  modport sink   (input valid, kind, timer_number, status, last, output ready);
endinterface

FILE: rtl/core/dltq_datapath.sv
// ----------------------------------------------------------------------------
// Delta-list timer queue datapath
// Holds the timer tables and list pointers and performs one list step a cycle.
// ----------------------------------------------------------------------------
module dltq_datapath #(
  parameter int NUM_TIMERS = dltq_pkg::NumTimersDef,
  parameter int TIME_WIDTH = dltq_pkg::TimeWidthDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dltq_pkg::dltq_cmd_t        cmd,
  output dltq_pkg::dltq_sts_t        sts,
  input  logic [dltq_pkg::IdW-1:0]   in_id,
  input  logic [dltq_pkg::IvW-1:0]   in_iv,
  output logic [dltq_pkg::IdW-1:0]   exp_id
);
  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam logic [TIME_WIDTH-1:0] TMAX = '1;

  logic [TIME_WIDTH-1:0] reload_r [NUM_TIMERS];
  logic [TIME_WIDTH-1:0] delta_r  [NUM_TIMERS];
  logic [IW-1:0]         link_r   [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] queued_r;
  logic [IW-1:0]         head_r;
  logic                  empty_r;
  logic [TIME_WIDTH-1:0] elapsed_r;
  logic [CW-1:0]         len_r;

  // Walk registers.
  logic [IW-1:0]         id_r;
  logic [IW-1:0]         p_r;
  logic [CW-1:0]         k_r;
  logic [TIME_WIDTH-1:0] agg_r;
  logic [TIME_WIDTH-1:0] d_r;

  // The command fields are held here because the input bus moves on after the beat.
  logic [dltq_pkg::IvW-1:0] iv_r;
  logic                     bad_r;

  logic [TIME_WIDTH-1:0] rem;
  logic [IW-1:0]         c;
  logic [TIME_WIDTH:0]   sum_w;
  logic [TIME_WIDTH-1:0] nxt_agg;
  logic [TIME_WIDTH-1:0] iv_sat;
  logic                  id_bad;

  function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
                                                   input logic [TIME_WIDTH-1:0] b);
    logic [TIME_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_WIDTH] ? TMAX : s[TIME_WIDTH-1:0];
  endfunction

  always_comb begin
    rem     = (elapsed_r >= delta_r[head_r]) ? '0 : delta_r[head_r] - elapsed_r;
    c       = link_r[p_r];
    sum_w   = {1'b0, agg_r} + {1'b0, delta_r[c]};
    nxt_agg = sum_w[TIME_WIDTH] ? TMAX : sum_w[TIME_WIDTH-1:0];
    id_bad  = ({{(32-dltq_pkg::IdW){1'b0}}, in_id} >= 32'(NUM_TIMERS));
    if (TIME_WIDTH >= dltq_pkg::IvW) begin
      iv_sat = TIME_WIDTH'(iv_r);
    end else begin
      iv_sat = ((iv_r >> TIME_WIDTH) != '0) ? TMAX : TIME_WIDTH'(iv_r);
    end
  end

  assign exp_id = dltq_pkg::IdW'(head_r);

  always_comb begin
    sts.queued    = queued_r[id_r];
    sts.empty     = empty_r;
    sts.is_head   = (id_r == head_r);
    sts.walk_hit  = (c == id_r);
    sts.walk_end  = (k_r >= len_r);
    sts.ins_front = (d_r < rem);
    sts.ins_stop  = (k_r >= len_r) || (nxt_agg > d_r);
    sts.tick_fire = (sat_add(elapsed_r, TIME_WIDTH'(1)) >= delta_r[head_r]);
    sts.exp_more  = (len_r > CW'(1)) && (delta_r[link_r[head_r]] == '0) &&
                    (k_r < CW'(dltq_pkg::MaxResults - 1));
    sts.id_bad    = bad_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        reload_r[i] <= '0;
        delta_r[i]  <= '0;
        link_r[i]   <= '0;
      end
      queued_r  <= '0;
      head_r    <= '0;
      empty_r   <= 1'b1;
      elapsed_r <= '0;
      len_r     <= '0;
      id_r      <= '0;
      p_r       <= '0;
      k_r       <= '0;
      agg_r     <= '0;
      d_r       <= '0;
      iv_r      <= '0;
      bad_r     <= 1'b0;
    end else begin
      unique case (cmd.op)
        dltq_pkg::OP_NONE: ;
        dltq_pkg::OP_LOAD: begin
          id_r  <= id_bad ? '0 : IW'(in_id);
          bad_r <= id_bad;
          iv_r  <= in_iv;
          p_r   <= head_r;
          k_r   <= CW'(1);
        end
        // Removing the head hands its remaining time to the successor.
        dltq_pkg::OP_STOP_HEAD: begin
          if (len_r > CW'(1)) begin
            delta_r[link_r[id_r]] <= sat_add(delta_r[link_r[id_r]], rem);
            head_r <= link_r[id_r];
          end else begin
            empty_r <= 1'b1;
          end
          elapsed_r      <= '0;
          queued_r[id_r] <= 1'b0;
          len_r          <= len_r - CW'(1);
        end
        dltq_pkg::OP_STOP_STEP: begin
          p_r <= c;
          k_r <= k_r + CW'(1);
        end
        dltq_pkg::OP_STOP_FIX: begin
          if (k_r + CW'(1) < len_r) begin
            link_r[p_r] <= link_r[c];
            delta_r[link_r[c]] <= sat_add(delta_r[link_r[c]], delta_r[c]);
          end
          queued_r[id_r] <= 1'b0;
          len_r          <= len_r - CW'(1);
        end
        dltq_pkg::OP_SET_WR: begin
          delta_r[id_r]  <= iv_sat;
          reload_r[id_r] <= iv_sat;
        end
        dltq_pkg::OP_START_CHK: begin
          d_r           <= reload_r[id_r];
          delta_r[id_r] <= reload_r[id_r];
          agg_r         <= rem;
          p_r           <= head_r;
          k_r           <= CW'(1);
          if (empty_r || len_r == '0) begin
            head_r    <= id_r;
            empty_r   <= 1'b0;
            elapsed_r <= '0;
            len_r     <= CW'(1);
            queued_r[id_r] <= 1'b1;
          end
        end
        dltq_pkg::OP_START_STEP: begin
          agg_r <= nxt_agg;
          p_r   <= c;
          k_r   <= k_r + CW'(1);
        end
        dltq_pkg::OP_START_LINK: begin
          delta_r[id_r] <= d_r - agg_r;
          if (k_r < len_r) begin
            delta_r[c] <= delta_r[c] - (d_r - agg_r);
            link_r[id_r] <= c;
          end
          link_r[p_r]    <= id_r;
          queued_r[id_r] <= 1'b1;
          len_r          <= len_r + CW'(1);
        end
        dltq_pkg::OP_START_FIN: begin
          delta_r[head_r] <= rem - d_r;
          link_r[id_r]    <= head_r;
          head_r          <= id_r;
          elapsed_r       <= '0;
          queued_r[id_r]  <= 1'b1;
          len_r           <= len_r + CW'(1);
        end
        dltq_pkg::OP_TICK: begin
          elapsed_r <= sat_add(elapsed_r, TIME_WIDTH'(1));
          k_r       <= '0;
          if (sts.tick_fire) delta_r[head_r] <= '0;
        end
        dltq_pkg::OP_EXPIRE: begin
          queued_r[head_r] <= 1'b0;
          len_r <= len_r - CW'(1);
          k_r   <= k_r + CW'(1);
          if (len_r == CW'(1)) empty_r <= 1'b1;
          else head_r <= link_r[head_r];
        end
        dltq_pkg::OP_EXP_END: elapsed_r <= '0;
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/core/dltq_ctrl.sv
// ----------------------------------------------------------------------------
// Delta-list timer queue controller
// Sequences list walks and result beats for one command or tick at a time.
// ----------------------------------------------------------------------------
module dltq_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [dltq_pkg::ActW-1:0] in_action,
  input  dltq_pkg::dltq_sts_t      sts,
  output dltq_pkg::dltq_cmd_t      cmd,
  input  logic [dltq_pkg::IdW-1:0] exp_id,
  input  logic [dltq_pkg::IdW-1:0] in_id,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_kind,
  output logic [2:0]               out_timer_number,
  output logic                     out_status,
  output logic                     out_last
);
  dltq_pkg::state_t state_r, state_nxt;
  logic [dltq_pkg::ActW-1:0] act_r;
  logic [dltq_pkg::IdW-1:0]  id_r;
  logic                      status_r, status_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic                      okind_r, okind_nxt, olast_r, olast_nxt;
  logic                      ostat_r, ostat_nxt;
  logic [2:0]                onum_r, onum_nxt;
  logic                      back_r, back_nxt;  // flag held at its reset value; no state sets or reads it

  assign in_ready         = (state_r == dltq_pkg::ST_IDLE);
  assign out_valid        = ovalid_r;
  assign out_kind         = okind_r;
  assign out_timer_number = onum_r;
  assign out_status       = ostat_r;
  assign out_last         = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dltq_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
      status_r <= 1'b0;
      back_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      status_r <= status_nxt;
      back_r   <= back_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r <= in_action;
      id_r  <= in_id;
    end
    okind_r <= okind_nxt;
    olast_r <= olast_nxt;
    ostat_r <= ostat_nxt;
    onum_r  <= onum_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '{op: dltq_pkg::OP_NONE};
    status_nxt = status_r;
    ovalid_nxt = ovalid_r && !out_ready;
    okind_nxt  = okind_r;
    olast_nxt  = olast_r;
    ostat_nxt  = ostat_r;
    onum_nxt   = onum_r;
    back_nxt   = back_r;
    unique case (state_r)
      dltq_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = dltq_pkg::OP_LOAD;
          status_nxt = 1'b0;
          state_nxt  = dltq_pkg::ST_DISPATCH;
        end
      end
      dltq_pkg::ST_DISPATCH: begin
        if (act_r == dltq_pkg::ACT_TICK) begin
          state_nxt = sts.empty ? dltq_pkg::ST_IDLE : dltq_pkg::ST_TICK;
        end else if (act_r > dltq_pkg::ACT_TICK) begin
          state_nxt = dltq_pkg::ST_IDLE;
        end else if (sts.id_bad) begin
          status_nxt = 1'b1;
          state_nxt  = dltq_pkg::ST_ACK;
        end else if (act_r == dltq_pkg::ACT_START) begin
          state_nxt = dltq_pkg::ST_START_CHK;
        end else begin
          state_nxt = dltq_pkg::ST_STOP_CHK;
        end
      end
      dltq_pkg::ST_STOP_CHK: begin
        if (!sts.queued || sts.empty) begin
          if (act_r == dltq_pkg::ACT_STOP) status_nxt = 1'b1;
          state_nxt = dltq_pkg::ST_SET_WR;
        end else if (sts.is_head) begin
          cmd.op    = dltq_pkg::OP_STOP_HEAD;
          state_nxt = dltq_pkg::ST_SET_WR;
        end else begin
          state_nxt = dltq_pkg::ST_STOP_WALK;
        end
      end
      dltq_pkg::ST_STOP_WALK: begin
        if (sts.walk_end) begin
          cmd.op    = dltq_pkg::OP_STOP_FIX;
          state_nxt = dltq_pkg::ST_SET_WR;
        end else if (sts.walk_hit) begin
          state_nxt = dltq_pkg::ST_STOP_FIX;
        end else begin
          cmd.op = dltq_pkg::OP_STOP_STEP;
        end
      end
      dltq_pkg::ST_STOP_FIX: begin
        cmd.op    = dltq_pkg::OP_STOP_FIX;
        state_nxt = dltq_pkg::ST_SET_WR;
      end
      dltq_pkg::ST_SET_WR: begin
        if (act_r == dltq_pkg::ACT_SET) begin
          cmd.op    = dltq_pkg::OP_SET_WR;
          state_nxt = dltq_pkg::ST_ACK;
        end else if (act_r == dltq_pkg::ACT_RESTART) begin
          state_nxt = dltq_pkg::ST_START_CHK;
        end else begin
          state_nxt = dltq_pkg::ST_ACK;
        end
      end
      dltq_pkg::ST_START_CHK: begin
        if (sts.queued) begin
          if (act_r == dltq_pkg::ACT_START) status_nxt = 1'b1;
          state_nxt = dltq_pkg::ST_ACK;
        end else begin
          cmd.op    = dltq_pkg::OP_START_CHK;
          state_nxt = sts.empty ? dltq_pkg::ST_ACK : dltq_pkg::ST_START_WALK;
        end
      end
      dltq_pkg::ST_START_WALK: begin
        if (sts.ins_front) begin
          cmd.op    = dltq_pkg::OP_START_FIN;
          state_nxt = dltq_pkg::ST_ACK;
        end else if (sts.ins_stop) begin
          cmd.op    = dltq_pkg::OP_START_LINK;
          state_nxt = dltq_pkg::ST_ACK;
        end else begin
          cmd.op = dltq_pkg::OP_START_STEP;
        end
      end
      dltq_pkg::ST_TICK: begin
        cmd.op    = dltq_pkg::OP_TICK;
        state_nxt = sts.tick_fire ? dltq_pkg::ST_EXP : dltq_pkg::ST_IDLE;
      end
      dltq_pkg::ST_EXP: begin
        if (!ovalid_nxt) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = dltq_pkg::KIND_EXPIRE;
          onum_nxt   = exp_id;
          ostat_nxt  = 1'b0;
          olast_nxt  = !sts.exp_more;
          cmd.op     = dltq_pkg::OP_EXPIRE;
          state_nxt  = sts.exp_more ? dltq_pkg::ST_EXP : dltq_pkg::ST_EXP_NEXT;
        end
      end
      dltq_pkg::ST_EXP_NEXT: begin
        cmd.op    = dltq_pkg::OP_EXP_END;
        state_nxt = dltq_pkg::ST_OUT_WAIT;
      end
      dltq_pkg::ST_ACK: begin
        if (!ovalid_nxt) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = dltq_pkg::KIND_ACK;
          onum_nxt   = id_r;
          ostat_nxt  = status_r;
          olast_nxt  = 1'b1;
          state_nxt  = dltq_pkg::ST_IDLE;
        end
      end
      dltq_pkg::ST_OUT_WAIT: state_nxt = dltq_pkg::ST_IDLE;
      default: state_nxt = dltq_pkg::ST_IDLE;
    endcase
  end
endmodule

FILE: rtl/core/delta_list_timer_queue.sv
// A new command is taken only in idle, after the last result beat of the one
// before is issued. Result stalls hold the queue; walks step one entry at a time.
// A tick with expiries gives one result beat per cycle while out_ready is high.
// Reset (synchronous, rst_n low) empties the list and clears all reloads.
// ----------------------------------------------------------------------------
// Delta-list timer queue top level
// Sorted one-shot timer list with relative delays, command and tick input.
// ----------------------------------------------------------------------------
module delta_list_timer_queue #(
  parameter int NUM_TIMERS = dltq_pkg::NumTimersDef,
  parameter int TIME_WIDTH = dltq_pkg::TimeWidthDef
) (
  input  logic clk,
  input  logic rst_n,
  dltq_in_if.sink    in_ch,
  dltq_out_if.source out_ch
);
  dltq_pkg::dltq_cmd_t      cmd;
  dltq_pkg::dltq_sts_t      sts;
  logic [dltq_pkg::IdW-1:0] exp_id;

  dltq_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_action(in_ch.action),
    .sts, .cmd, .exp_id, .in_id(in_ch.timer_id),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.kind),
    .out_timer_number(out_ch.timer_number), .out_status(out_ch.status),
    .out_last(out_ch.last)
  );

  dltq_datapath #(.NUM_TIMERS(NUM_TIMERS), .TIME_WIDTH(TIME_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_id(in_ch.timer_id), .in_iv(in_ch.interval), .exp_id
  );
endmodule

FILE: rtl/core/dltq_checker.sv
// ----------------------------------------------------------------------------
// Delta-list timer queue checker
// Port-level checks on the result channel and the input handshake.
// ----------------------------------------------------------------------------
module dltq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic       out_status,
  input logic       out_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
  a_exp_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> !out_status) else $error("expiry with status set");
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_last) else $error("ack without last");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready right after accept");
endmodule

bind delta_list_timer_queue dltq_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.kind),
  .out_status(out_ch.status), .out_last(out_ch.last)
);

FILE: test/tb_delta_list_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-list timer queue testbench
// Drives timer commands and ticks through the valid/ready channels. Every
// accepted beat updates a behavioral timer list. That list predicts the
// acknowledgements and expiry beats, which are checked in order.
// ----------------------------------------------------------------------------
module tb_delta_list_timer_queue;

  localparam int          NTIM      = 8;
  localparam logic [63:0] TMAX      = 64'hFFFF_FFFF;
  localparam int          PAUSE_AT  = 200;
  localparam int          STALL_AT  = 40;

  typedef struct packed {
    logic [2:0]  act;
    logic [2:0]  id;
    logic [31:0] iv;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] num;
    logic       status;
    logic       last;
  } timer_evt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dltq_in_if  in_bus ();
  dltq_out_if out_bus ();

  delta_list_timer_queue DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #1 clk = ~clk;

  cmd_t       pending_cmds[$];
  timer_evt_t expected_evts[$];
  int         errors = 0;
  int         accepted = 0;
  int         evt_seen = 0;
  bit         pause_done = 1'b0;
  bit         stall_done = 1'b0;
  bit         calm;

  // Behavioral timer list
  logic [63:0] reload[NTIM];
  logic [63:0] delta[NTIM];
  int          link[NTIM];
  bit          queued[NTIM];
  int          head;
  bit          empty;
  logic [63:0] elapsed;
  int          qlen;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > TMAX) ? TMAX : s;
  endfunction

  function automatic logic [63:0] head_left();
    return (elapsed >= delta[head]) ? 64'd0 : delta[head] - elapsed;
  endfunction

  function automatic bit unlink_timer(int id);
    int p;
    int c;
    int s;
    if (!queued[id] || empty) return 1'b0;
    if (id == head) begin
      if (qlen > 1) begin
        s = link[id];
        delta[s] = sat_sum(delta[s], head_left());
        head = s;
      end else begin
        empty = 1'b1;
      end
      elapsed = 0;
    end else begin
      p = head;
      for (int k = 1; k < qlen; k++) begin
        c = link[p];
        if (c == id) begin
          if (k + 1 < qlen) begin
            s = link[c];
            link[p] = s;
            delta[s] = sat_sum(delta[s], delta[c]);
          end
          break;
        end
        p = c;
      end
    end
    queued[id] = 1'b0;
    if (qlen > 0) qlen--;
    return 1'b1;
  endfunction

  function automatic bit link_timer(int id);
    logic [63:0] d;
    logic [63:0] rem;
    logic [63:0] agg;
    logic [63:0] nsum;
    int p;
    int c;
    int pos;
    if (queued[id]) return 1'b0;
    d = reload[id];
    delta[id] = d;
    if (empty || qlen == 0) begin
      head = id;
      empty = 1'b0;
      elapsed = 0;
      qlen = 0;
    end else begin
      rem = head_left();
      if (d < rem) begin
        delta[head] = rem - d;
        link[id] = head;
        head = id;
        elapsed = 0;
      end else begin
        agg = rem;
        p = head;
        pos = 1;
        while (pos < qlen) begin
          c = link[p];
          nsum = sat_sum(agg, delta[c]);
          if (nsum > d) break;
          agg = nsum;
          p = c;
          pos++;
        end
        delta[id] = d - agg;
        if (pos < qlen) begin
          c = link[p];
          delta[c] = delta[c] - delta[id];
          link[id] = c;
        end
        link[p] = id;
      end
    end
    queued[id] = 1'b1;
    qlen++;
    return 1'b1;
  endfunction

  task automatic predict_timer_events(cmd_t c);
    timer_evt_t e;
    int n;
    int h;
    bit st;
    n = 0;
    st = 1'b0;
    if (c.act == dltq_pkg::ACT_TICK) begin
      if (empty) return;
      elapsed = sat_sum(elapsed, 1);
      if (elapsed < delta[head]) return;
      delta[head] = 0;
      while (!empty && delta[head] == 0 && n < dltq_pkg::MaxResults) begin
        h = head;
        e.kind = dltq_pkg::KIND_EXPIRE;
        e.num = h[2:0];
        e.status = 1'b0;
        e.last = 1'b0;
        expected_evts.push_back(e);
        n++;
        queued[h] = 1'b0;
        if (qlen > 0) qlen--;
        if (qlen == 0) empty = 1'b1;
        else head = link[h];
      end
      elapsed = 0;
      if (n > 0) expected_evts[expected_evts.size()-1].last = 1'b1;
      return;
    end
    if (c.act > dltq_pkg::ACT_TICK) return;
    case (c.act)
      dltq_pkg::ACT_SET: begin
        void'(unlink_timer(c.id));
        delta[c.id] = {32'd0, c.iv};
        reload[c.id] = {32'd0, c.iv};
      end
      dltq_pkg::ACT_START: st = !link_timer(c.id);
      dltq_pkg::ACT_STOP: st = !unlink_timer(c.id);
      default: begin
        void'(unlink_timer(c.id));
        void'(link_timer(c.id));
      end
    endcase
    e.kind = dltq_pkg::KIND_ACK;
    e.num = c.id;
    e.status = st;
    e.last = 1'b1;
    expected_evts.push_back(e);
  endtask

  // Sender
  int gap = 0;
  always @(posedge clk) begin
    cmd_t c;
    bit   hold;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        predict_timer_events({in_bus.action, in_bus.timer_id, in_bus.interval});
        accepted++;
      end
      calm = (accepted >= 120 && accepted < 170);
      if (!(in_bus.valid && !in_bus.ready)) begin
        hold = 1'b0;
        if (!pause_done && accepted >= PAUSE_AT) begin
          if (expected_evts.size() == 0) pause_done = 1'b1;
          else hold = 1'b1;
        end
        if (gap > 0) begin
          gap--;
          in_bus.valid <= 1'b0;
        end else if (hold || pending_cmds.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else begin
          c = pending_cmds.pop_front();
          in_bus.valid    <= 1'b1;
          in_bus.action   <= c.act;
          in_bus.timer_id <= c.id;
          in_bus.interval <= c.iv;
          if (!calm && $urandom_range(0, 9) < 4)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
      end
    end
  end

  // Receiver and checker
  int stall = 0;
  always @(posedge clk) begin
    timer_evt_t got;
    timer_evt_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.kind, out_bus.timer_number, out_bus.status, out_bus.last};
        evt_seen++;
        if (expected_evts.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result beat %p", got);
        end else begin
          want = expected_evts.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (!stall_done && evt_seen >= STALL_AT) begin
        stall_done = 1'b1;
        stall = 300;
      end
      if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) < 3) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  function automatic cmd_t mk(logic [2:0] a, int id, logic [31:0] iv);
    cmd_t c;
    c.act = a;
    c.id = id[2:0];
    c.iv = iv;
    return c;
  endfunction

  function automatic logic [31:0] rand_interval();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return $urandom_range(0, 6);
    if (r == 8) return $urandom();
    return 32'hFFFF_FFFF - $urandom_range(0, 3);
  endfunction

  initial begin
    int r;
    logic [2:0] a;
    in_bus.valid = 1'b0;
    in_bus.action = dltq_pkg::ACT_TICK;
    in_bus.timer_id = '0;
    in_bus.interval = '0;
    out_bus.ready = 1'b0;
    for (int i = 0; i < NTIM; i++) begin
      reload[i] = 0;
      delta[i] = 0;
      link[i] = 0;
      queued[i] = 1'b0;
    end
    head = 0;
    empty = 1'b1;
    elapsed = 0;
    qlen = 0;

    // All timers with zero delay expire on one tick.
    for (int i = 0; i < NTIM; i++) begin
      pending_cmds.push_back(mk(dltq_pkg::ACT_SET, i, 32'd0));
      pending_cmds.push_back(mk(dltq_pkg::ACT_START, i, 32'd0));
    end
    pending_cmds.push_back(mk(dltq_pkg::ACT_TICK, 0, 32'd0));
    pending_cmds.push_back(mk(dltq_pkg::ACT_SET, 7, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk(dltq_pkg::ACT_START, 7, 32'd0));
    pending_cmds.push_back(mk(dltq_pkg::ACT_START, 7, 32'd0));
    pending_cmds.push_back(mk(dltq_pkg::ACT_STOP, 3, 32'd0));
    pending_cmds.push_back(mk(dltq_pkg::ACT_RESTART, 7, 32'd0));
    pending_cmds.push_back(mk(dltq_pkg::ACT_STOP, 7, 32'd0));
    pending_cmds.push_back(mk(3'd5, 2, 32'd1));
    pending_cmds.push_back(mk(3'd7, 5, 32'd1));
    pending_cmds.push_back(mk(dltq_pkg::ACT_TICK, 0, 32'd0));

    for (int n = 0; n < 430; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) a = dltq_pkg::ACT_TICK;
      else if (r < 60) a = dltq_pkg::ACT_START;
      else if (r < 75) a = dltq_pkg::ACT_SET;
      else if (r < 85) a = dltq_pkg::ACT_STOP;
      else if (r < 95) a = dltq_pkg::ACT_RESTART;
      else a = 3'($urandom_range(5, 7));
      pending_cmds.push_back(mk(a, $urandom_range(0, 7), rand_interval()));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_bus.valid) @(posedge clk);
    while (expected_evts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_evts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/dltq_pkg.sv
rtl/core/dltq_if.sv
rtl/core/dltq_datapath.sv
rtl/core/dltq_ctrl.sv
rtl/core/delta_list_timer_queue.sv
rtl/core/dltq_checker.sv
test/tb_delta_list_timer_queue.sv
